// ===== hw/rtl/pc_pkg.sv =====
// ----------------------------------------------------------------------------
// pc_pkg
// Shared types and constants of the correlation coefficient block.
// ----------------------------------------------------------------------------
`default_nettype none

package pc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 4096;
    localparam int CNT_W       = 13;
    localparam int SUM_W       = 29;
    localparam int SQ_W        = 44;
    localparam int VAR_W       = 60;
    localparam int COEF_W      = 16;
    localparam int PW          = 148;
    localparam int BW          = 64;
    localparam int BITS_W      = 7;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x_sample;
        logic signed [SAMPLE_BITS-1:0] y_sample;
        logic                          last;
    } t_in;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic                     undefined;
        logic                     overflowed;
        logic [CNT_W-1:0]         pair_count;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [PW-1:0]     a;
        logic [BW-1:0]     b;
        logic [BITS_W-1:0] nbits;
    } t_mul_req;

    typedef struct packed {
        logic          done;
        logic [PW-1:0] product;
    } t_mul_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/pearson_correlation.sv =====
// ----------------------------------------------------------------------------
// pearson_correlation
// Pearson correlation of paired samples, Q1.15 result per data set.
// ----------------------------------------------------------------------------
// channel  dir  handshake                payload
// in       in   i_in_valid / o_in_stall  i_in  (t_in)
// out      out  o_out_valid / i_out_stall o_out (t_out)
//
// One shared shift-add multiplier, one bit per cycle, does all products.
// A pair takes three 16-bit products; the closing pair adds the cross terms,
// the variance product and a 16-step root search, the last two of which are
// skipped when a variance term is zero.
// Reset is synchronous and clears all sums. A result waits in the output
// register; the next data set's pairs are taken while it is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pearson_correlation
    import pc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_AXY  = 5'd1;
    localparam logic [4:0] ST_AXX  = 5'd2;
    localparam logic [4:0] ST_AYY  = 5'd3;
    localparam logic [4:0] ST_N1   = 5'd4;
    localparam logic [4:0] ST_N2   = 5'd5;
    localparam logic [4:0] ST_VX1  = 5'd6;
    localparam logic [4:0] ST_VX2  = 5'd7;
    localparam logic [4:0] ST_VY1  = 5'd8;
    localparam logic [4:0] ST_VY2  = 5'd9;
    localparam logic [4:0] ST_CHK  = 5'd10;
    localparam logic [4:0] ST_LHS  = 5'd11;
    localparam logic [4:0] ST_PROD = 5'd12;
    localparam logic [4:0] ST_SQ   = 5'd13;
    localparam logic [4:0] ST_TST  = 5'd14;
    localparam logic [4:0] ST_COEF = 5'd15;
    localparam logic [4:0] ST_OUT  = 5'd16;

    logic [4:0]                    r_state, n_state;
    logic                          r_started, n_started;
    logic signed [SAMPLE_BITS-1:0] r_x, n_x, r_y, n_y;
    logic                          r_last, n_last;
    logic [CNT_W-1:0]              r_count, n_count;
    logic signed [SUM_W-1:0]       r_sx, n_sx, r_sy, n_sy;
    logic signed [SQ_W-1:0]        r_sxy, n_sxy;
    logic [SQ_W-1:0]               r_sxx, n_sxx, r_syy, n_syy;
    logic                          r_ovf, n_ovf;
    logic signed [VAR_W-1:0]       r_t1, n_t1, r_num, n_num, r_vx, n_vx, r_vy, n_vy;
    logic [PW-1:0]                 r_lhs, n_lhs, r_prod, n_prod;
    logic [31:0]                   r_tt, n_tt;
    logic [COEF_W-1:0]             r_q, n_q;
    logic [3:0]                    r_bit, n_bit;
    logic                          r_undef, n_undef;
    logic signed [COEF_W-1:0]      r_coef, n_coef;
    t_out                          r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic [SAMPLE_BITS-1:0] xm, ym;
    logic [SUM_W-1:0]       sxm, sym;
    logic [SQ_W-1:0]        sxym;
    logic [VAR_W-1:0]       numm;
    logic [COEF_W-1:0]      t_try, q_clamp;
    logic signed [VAR_W-1:0] p_sig;

    pc_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign xm    = r_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_x) : SAMPLE_BITS'(r_x);
    assign ym    = r_y[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_y) : SAMPLE_BITS'(r_y);
    assign sxm   = r_sx[SUM_W-1] ? SUM_W'(-r_sx) : SUM_W'(r_sx);
    assign sym   = r_sy[SUM_W-1] ? SUM_W'(-r_sy) : SUM_W'(r_sy);
    assign sxym  = r_sxy[SQ_W-1] ? SQ_W'(-r_sxy) : SQ_W'(r_sxy);
    assign numm  = r_num[VAR_W-1] ? VAR_W'(-r_num) : VAR_W'(r_num);
    assign t_try = r_q | (COEF_W'(1) << r_bit);
    assign p_sig = VAR_W'(mul_rsp.product);
    assign q_clamp = (r_q > COEF_W'(32768)) ? COEF_W'(32768) : r_q;

    // operand select for the shared multiplier
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        mul_req.nbits = '0;
        case (r_state)
            ST_AXY: begin
                mul_req.a = PW'(xm); mul_req.b = BW'(ym); mul_req.nbits = BITS_W'(SAMPLE_BITS);
            end
            ST_AXX: begin
                mul_req.a = PW'(xm); mul_req.b = BW'(xm); mul_req.nbits = BITS_W'(SAMPLE_BITS);
            end
            ST_AYY: begin
                mul_req.a = PW'(ym); mul_req.b = BW'(ym); mul_req.nbits = BITS_W'(SAMPLE_BITS);
            end
            ST_N1: begin
                mul_req.a = PW'(sxym); mul_req.b = BW'(r_count); mul_req.nbits = BITS_W'(CNT_W);
            end
            ST_N2: begin
                mul_req.a = PW'(sxm); mul_req.b = BW'(sym); mul_req.nbits = BITS_W'(SUM_W);
            end
            ST_VX1: begin
                mul_req.a = PW'(r_sxx); mul_req.b = BW'(r_count); mul_req.nbits = BITS_W'(CNT_W);
            end
            ST_VX2: begin
                mul_req.a = PW'(sxm); mul_req.b = BW'(sxm); mul_req.nbits = BITS_W'(SUM_W);
            end
            ST_VY1: begin
                mul_req.a = PW'(r_syy); mul_req.b = BW'(r_count); mul_req.nbits = BITS_W'(CNT_W);
            end
            ST_VY2: begin
                mul_req.a = PW'(sym); mul_req.b = BW'(sym); mul_req.nbits = BITS_W'(SUM_W);
            end
            ST_LHS: begin
                mul_req.a = PW'(numm); mul_req.b = BW'(numm); mul_req.nbits = BITS_W'(VAR_W);
            end
            ST_PROD: begin
                mul_req.a = PW'(unsigned'(r_vx)); mul_req.b = BW'(unsigned'(r_vy));
                mul_req.nbits = BITS_W'(VAR_W);
            end
            ST_SQ: begin
                mul_req.a = PW'(t_try); mul_req.b = BW'(t_try); mul_req.nbits = BITS_W'(COEF_W);
            end
            ST_TST: begin
                mul_req.a = r_prod; mul_req.b = BW'(r_tt); mul_req.nbits = BITS_W'(32);
            end
            default: begin
                mul_req.a = '0;
            end
        endcase
        if (r_state != ST_IDLE && r_state != ST_CHK && r_state != ST_COEF
            && r_state != ST_OUT) begin
            mul_req.start = !r_started;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_x         = r_x;
        n_y         = r_y;
        n_last      = r_last;
        n_count     = r_count;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_sxy       = r_sxy;
        n_sxx       = r_sxx;
        n_syy       = r_syy;
        n_ovf       = r_ovf;
        n_t1        = r_t1;
        n_num       = r_num;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_lhs       = r_lhs;
        n_prod      = r_prod;
        n_tt        = r_tt;
        n_q         = r_q;
        n_bit       = r_bit;
        n_undef     = r_undef;
        n_coef      = r_coef;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (mul_req.start) begin
            n_started = 1'b1;
        end
        if (mul_rsp.done) begin
            n_started = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_x    = i_in.x_sample;
                    n_y    = i_in.y_sample;
                    n_last = i_in.last;
                    if (r_count < CNT_W'(MAX_SAMPLES)) begin
                        n_count = r_count + 1'b1;
                        n_sx    = r_sx + SUM_W'(i_in.x_sample);
                        n_sy    = r_sy + SUM_W'(i_in.y_sample);
                        n_state = ST_AXY;
                    end else begin
                        n_ovf   = 1'b1;
                        n_state = i_in.last ? ST_N1 : ST_IDLE;
                    end
                end
            end
            ST_AXY: if (mul_rsp.done) begin
                if (r_x[SAMPLE_BITS-1] ^ r_y[SAMPLE_BITS-1]) begin
                    n_sxy = r_sxy - SQ_W'(mul_rsp.product);
                end else begin
                    n_sxy = r_sxy + SQ_W'(mul_rsp.product);
                end
                n_state = ST_AXX;
            end
            ST_AXX: if (mul_rsp.done) begin
                n_sxx   = r_sxx + SQ_W'(mul_rsp.product);
                n_state = ST_AYY;
            end
            ST_AYY: if (mul_rsp.done) begin
                n_syy   = r_syy + SQ_W'(mul_rsp.product);
                n_state = r_last ? ST_N1 : ST_IDLE;
            end
            ST_N1: if (mul_rsp.done) begin
                n_t1    = r_sxy[SQ_W-1] ? -p_sig : p_sig;
                n_state = ST_N2;
            end
            ST_N2: if (mul_rsp.done) begin
                n_num   = (r_sx[SUM_W-1] ^ r_sy[SUM_W-1]) ? r_t1 + p_sig : r_t1 - p_sig;
                n_state = ST_VX1;
            end
            ST_VX1: if (mul_rsp.done) begin
                n_t1    = p_sig;
                n_state = ST_VX2;
            end
            ST_VX2: if (mul_rsp.done) begin
                n_vx    = r_t1 - p_sig;
                n_state = ST_VY1;
            end
            ST_VY1: if (mul_rsp.done) begin
                n_t1    = p_sig;
                n_state = ST_VY2;
            end
            ST_VY2: if (mul_rsp.done) begin
                n_vy    = r_t1 - p_sig;
                n_state = ST_CHK;
            end
            ST_CHK: begin
                n_q   = '0;
                n_bit = 4'd15;
                if (r_vx == '0 || r_vy == '0) begin
                    n_undef = 1'b1;
                    n_coef  = '0;
                    n_state = ST_OUT;
                end else begin
                    n_undef = 1'b0;
                    n_state = ST_LHS;
                end
            end
            ST_LHS: if (mul_rsp.done) begin
                n_lhs   = {mul_rsp.product[PW-31:0], 30'b0};
                n_state = ST_PROD;
            end
            ST_PROD: if (mul_rsp.done) begin
                n_prod  = mul_rsp.product;
                n_state = ST_SQ;
            end
            ST_SQ: if (mul_rsp.done) begin
                n_tt    = mul_rsp.product[31:0];
                n_state = ST_TST;
            end
            ST_TST: if (mul_rsp.done) begin
                if (mul_rsp.product <= r_lhs) begin
                    n_q = t_try;
                end
                if (r_bit == 4'd0) begin
                    n_state = ST_COEF;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = ST_SQ;
                end
            end
            ST_COEF: begin
                if (r_num[VAR_W-1]) begin
                    n_coef = COEF_W'(-q_clamp);
                end else if (q_clamp > COEF_W'(32767)) begin
                    n_coef = COEF_W'(32767);
                end else begin
                    n_coef = q_clamp;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.coefficient = r_coef;
                    n_out.undefined   = r_undef;
                    n_out.overflowed  = r_ovf;
                    n_out.pair_count  = r_count;
                    n_out_valid       = 1'b1;
                    n_count = '0;
                    n_sx    = '0;
                    n_sy    = '0;
                    n_sxy   = '0;
                    n_sxx   = '0;
                    n_syy   = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_last <= n_last;
        r_t1   <= n_t1;
        r_num  <= n_num;
        r_vx   <= n_vx;
        r_vy   <= n_vy;
        r_lhs  <= n_lhs;
        r_prod <= n_prod;
        r_tt   <= n_tt;
        r_q    <= n_q;
        r_bit  <= n_bit;
        r_undef <= n_undef;
        r_coef <= n_coef;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_started   <= 1'b0;
            r_count     <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sxy       <= '0;
            r_sxx       <= '0;
            r_syy       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_count     <= n_count;
            r_sx        <= n_sx;
            r_sy        <= n_sy;
            r_sxy       <= n_sxy;
            r_sxx       <= n_sxx;
            r_syy       <= n_syy;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/pc_serial_mul.sv =====
// ----------------------------------------------------------------------------
// pc_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pc_serial_mul
    import pc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic [PW-1:0]     r_acc, n_acc;
    logic [PW-1:0]     r_a, n_a;
    logic [BW-1:0]     r_b, n_b;
    logic [BITS_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_acc  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_cnt  = i_req.nbits;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = {r_a[PW-2:0], 1'b0};
            n_b   = {1'b0, r_b[BW-1:1]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == BITS_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Pearson correlation block. A queue of sample
// pairs feeds a clocked driver; a clocked monitor compares each result
// transfer with a local wide-integer predictor of the coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import pc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    pearson_correlation u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    t_in  pending_pairs[$];
    t_out expected_coefs[$];

    int   idle_pct;
    int   stall_pct;
    bit   hold_out;
    int   mismatches;
    int   results_seen;
    int   undefined_seen;
    int   overflow_seen_cnt;
    int   sets_sent;

    // predictor state
    int     acc_n;
    longint acc_x, acc_y, acc_xy, acc_xx, acc_yy;
    bit     acc_dropped;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    function automatic t_out close_set();
        t_out r;
        logic signed [255:0] n, sx, sy, num, vx, vy;
        logic [255:0] mag, lhs, prod, t;
        logic [16:0] q;
        bit neg;
        n   = 256'(acc_n);
        sx  = 256'(acc_x);
        sy  = 256'(acc_y);
        num = n * $signed(256'(acc_xy)) - sx * sy;
        vx  = n * $signed(256'(acc_xx)) - sx * sx;
        vy  = n * $signed(256'(acc_yy)) - sy * sy;
        r = '0;
        if (vx == 0 || vy == 0) begin
            r.undefined = 1'b1;
        end else begin
            neg  = num < 0;
            mag  = neg ? -num : num;
            lhs  = (mag * mag) << 30;
            prod = vx * vy;
            q = '0;
            for (int b = 15; b >= 0; b--) begin
                t = 256'(q | (17'd1 << b));
                if (t * t * prod <= lhs) q = t[16:0];
            end
            if (q > 17'd32768) q = 17'd32768;
            if (neg) r.coefficient = -q[15:0];
            else r.coefficient = (q > 17'd32767) ? 16'sd32767 : q[15:0];
        end
        r.overflowed = acc_dropped;
        r.pair_count = acc_n[CNT_W-1:0];
        return r;
    endfunction

    task automatic absorb_pair(input t_in p);
        longint xv, yv;
        xv = p.x_sample;
        yv = p.y_sample;
        if (acc_n < MAX_SAMPLES) begin
            acc_n++;
            acc_x  += xv;
            acc_y  += yv;
            acc_xy += xv * yv;
            acc_xx += xv * xv;
            acc_yy += yv * yv;
        end else begin
            acc_dropped = 1'b1;
        end
        if (p.last) begin
            expected_coefs = {expected_coefs, close_set()};
            acc_n = 0;
            acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
            acc_dropped = 1'b0;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in       <= '0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) absorb_pair(i_in);
            if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_in       <= pending_pairs.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_coefs.size() == 0) begin
                report("unexpected transfer", 32'(o_out.pair_count), 32'd0);
            end else begin
                want = expected_coefs.pop_front();
                if (o_out.coefficient !== want.coefficient)
                    report("coefficient", 32'(signed'(o_out.coefficient)),
                           32'(signed'(want.coefficient)));
                if (o_out.undefined !== want.undefined)
                    report("undefined", 32'(o_out.undefined), 32'(want.undefined));
                if (o_out.overflowed !== want.overflowed)
                    report("overflowed", 32'(o_out.overflowed), 32'(want.overflowed));
                if (o_out.pair_count !== want.pair_count)
                    report("pair_count", 32'(o_out.pair_count), 32'(want.pair_count));
                if (want.undefined) undefined_seen++;
                if (want.overflowed) overflow_seen_cnt++;
            end
            results_seen++;
        end
        i_out_stall <= hold_out || ($urandom_range(99) < stall_pct);
    end

    task automatic push_pair(input logic [15:0] x, input logic [15:0] y, input bit l);
        t_in p;
        p.x_sample = x;
        p.y_sample = y;
        p.last     = l;
        pending_pairs = {pending_pairs, p};
        if (l) sets_sent++;
    endtask

    task automatic random_set(input int len);
        int shape;
        logic signed [15:0] x, y;
        shape = $urandom_range(4);
        for (int i = 0; i < len; i++) begin
            x = 16'($urandom);
            case (shape)
                0: y = 16'($urandom);
                1: y = (x >>> 1) + 16'(signed'($urandom_range(64)) - 32);
                2: y = -(x >>> 2) + 16'(signed'($urandom_range(16)) - 8);
                3: begin
                    x = 16'(signed'($urandom_range(6)) - 3);
                    y = 16'(signed'($urandom_range(6)) - 3);
                end
                default: y = x;
            endcase
            push_pair(x, y, i == len - 1);
        end
    endtask

    task automatic random_sets(input int items);
        int len;
        while (items > 0) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(1, 10);
            random_set(len);
            items -= len;
        end
    endtask

    task automatic drain();
        while (pending_pairs.size() > 0 || i_in_valid || expected_coefs.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        hold_out    = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        mismatches  = 0;
        results_seen = 0;
        undefined_seen = 0;
        overflow_seen_cnt = 0;
        sets_sent   = 0;
        acc_n = 0;
        acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
        acc_dropped = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single pair, constant x, perfect +1 and -1, extremes
        push_pair(16'sd5, 16'sd7, 1'b1);
        push_pair(16'sd3, 16'sd1, 1'b0);
        push_pair(16'sd3, -16'sd9, 1'b1);
        push_pair(16'h8000, 16'h8000, 1'b0);
        push_pair(16'h7fff, 16'h7fff, 1'b1);
        push_pair(16'h8000, 16'h7fff, 1'b0);
        push_pair(16'h7fff, 16'h8000, 1'b1);
        push_pair(16'h8000, 16'h8000, 1'b0);
        push_pair(16'h7fff, 16'h8000, 1'b0);
        push_pair(16'h0000, 16'h7fff, 1'b1);
        push_pair(16'hffff, 16'h0001, 1'b0);
        push_pair(16'h0001, 16'hffff, 1'b0);
        push_pair(16'h0002, 16'h5555, 1'b1);
        push_pair(16'h1234, 16'haaaa, 1'b0);
        push_pair(16'hedcb, 16'h5555, 1'b0);
        push_pair(16'h0000, 16'h0000, 1'b1);
        drain();

        // capacity: 4096 pairs, one dropped, then a dropped closing pair
        for (int i = 0; i < MAX_SAMPLES + 1; i++)
            push_pair(16'($urandom), 16'($urandom), 1'b0);
        push_pair(16'h7fff, 16'h8000, 1'b1);
        drain();

        random_sets(220);
        drain();
        idle_pct = 85;
        random_sets(220);
        drain();
        idle_pct = 0;
        stall_pct = 85;
        random_sets(220);
        drain();
        idle_pct = 7;
        stall_pct = 7;
        random_sets(220);
        drain();

        // long receiver hold while pairs keep coming
        idle_pct = 0;
        stall_pct = 0;
        random_sets(220);
        fork
            begin
                hold_out = 1'b1;
                repeat (6000) @(posedge i_clk);
                hold_out = 1'b0;
            end
        join
        drain();

        repeat (2000) @(posedge i_clk);
        $display("covered %0d data sets, %0d results checked (%0d undefined, %0d over capacity)",
                 sets_sent, results_seen, undefined_seen, overflow_seen_cnt);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_coefs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
